FILE: src/sle_pkg.sv
// shared constants and codes for the serial line editor
// no dependencies; imported by serial_line_editor
package sle_pkg;

    localparam int DATA_W   = 8;
    localparam int CNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam int LINE_CAPACITY_DEF = 32;

    // received key codes
    localparam logic [DATA_W-1:0] KEY_DELETE = 8'h7f;
    localparam logic [DATA_W-1:0] KEY_RETURN = 8'h0d;
    localparam logic [DATA_W-1:0] KEY_BELL   = 8'h07;
    localparam logic [DATA_W-1:0] STAR_BYTE  = 8'h2a;
    localparam logic [DATA_W-1:0] PRINT_LOW  = 8'd32;
    localparam logic [DATA_W-1:0] PRINT_HIGH = 8'd126;

    // result kinds
    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // echo modes
    localparam logic [1:0] ECHO_OFF  = 2'd0;
    localparam logic [1:0] ECHO_CHAR = 2'd1;
    localparam logic [1:0] ECHO_STAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;

    localparam logic [1:0]            ECHO_MODE_RST  = ECHO_CHAR;
    localparam logic [CFG_DATA_W-1:0] MAX_LENGTH_RST = 6'd32;

endpackage

FILE: src/sle_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/serial_line_editor.sv
// serial line editor top level: line buffer control, echo and line readout
// depends on sle_pkg and sle_ram
//
// channel   direction  handshake           payload
// in        in         in_valid/in_stall   rx_byte
// out       out        out_valid/out_stall kind, out_byte, line_length, last
// cfg       in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// a byte other than carriage return is handled when accepted; its result, if any, lands in
// the output register on the accept edge
// carriage return reads the line out of the ram one beat per cycle while the output
// is not stalled, and the input is stalled until the last beat is loaded
// reset clears count, skip flag, state, readout position and output valid and loads the config defaults;
// the output payload and the line ram have no reset; a stalled output holds the current beat and stops
// the readout; input is stalled whenever the output register cannot take a new beat
module serial_line_editor
#(
    parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [sle_pkg::DATA_W-1:0]       rx_byte,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       kind,
    output logic [sle_pkg::DATA_W-1:0]       out_byte,
    output logic [sle_pkg::CNT_W-1:0]        line_length,
    output logic                             last,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sle_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sle_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import sle_pkg::*;

    localparam int ADDR_W = $clog2(LINE_CAPACITY);
    // kept characters are capped by the buffer and by the 5 bit count
    localparam int KEEP_MAX = (LINE_CAPACITY - 1 < 31) ? LINE_CAPACITY - 1 : 31;
    localparam logic [CFG_DATA_W-1:0] KEEP_MAX_V = CFG_DATA_W'(KEEP_MAX);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 skip_reg, skip_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;   // line readout position
    logic [CNT_W-1:0]     n_reg, n_next;       // length of the line being read out
    logic [1:0]           echo_mode_reg;
    logic [CFG_DATA_W-1:0] max_length_reg;

    logic                 out_valid_reg;
    logic [1:0]           kind_reg, kind_next;
    logic [DATA_W-1:0]    byte_reg, byte_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic                 last_reg, last_next;
    logic                 out_load;

    logic                 can_load;
    logic                 in_accept;
    logic [CFG_DATA_W-1:0] lim_raw;
    logic [CFG_DATA_W-1:0] lim_eff;
    logic                 room;
    logic                 printable;
    logic [CNT_W-1:0]     idx_inc;

    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [DATA_W-1:0]    ram_rd_data;

    // output register takes a beat when empty or being drained
    assign can_load  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && can_load);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // keep limit: max_length minus one, floored at zero, capped
    assign lim_raw   = (max_length_reg >= CFG_DATA_W'(1)) ? max_length_reg - CFG_DATA_W'(1)
                                                          : '0;
    assign lim_eff   = (lim_raw > KEEP_MAX_V) ? KEEP_MAX_V : lim_raw;
    assign room      = CFG_DATA_W'(count_reg) < lim_eff;
    assign printable = (rx_byte >= PRINT_LOW) && (rx_byte <= PRINT_HIGH);
    assign idx_inc   = idx_reg + CNT_W'(1);

    // writes happen only on printable beats in idle; readout starts on a later
    // edge, so a read never meets a write to the same entry
    sle_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LINE_CAPACITY)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_W'(count_reg)),
        .wr_data (rx_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        skip_next   = skip_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        out_load    = 1'b0;
        kind_next   = KIND_ECHO;
        byte_next   = '0;
        len_next    = '0;
        last_next   = 1'b1;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    priority if (skip_reg)
                    begin
                        // byte after a delete is swallowed
                        skip_next = 1'b0;
                    end
                    else if (rx_byte == KEY_DELETE)
                    begin
                        out_load = 1'b1;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                            skip_next  = 1'b1;
                            byte_next  = KEY_DELETE;
                        end
                        else
                        begin
                            byte_next = KEY_BELL;
                        end
                    end
                    else if (rx_byte == KEY_RETURN)
                    begin
                        count_next = '0;
                        if (count_reg == '0)
                        begin
                            out_load  = 1'b1;
                            kind_next = KIND_EMPTY;
                        end
                        else
                        begin
                            // fetch the first character, beats follow from dump
                            state_next  = ST_DUMP;
                            n_next      = count_reg;
                            idx_next    = '0;
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                        end
                    end
                    else if (printable && room)
                    begin
                        ram_wr_en  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        unique case (echo_mode_reg)
                            ECHO_CHAR:
                            begin
                                out_load  = 1'b1;
                                byte_next = rx_byte;
                            end
                            ECHO_STAR:
                            begin
                                out_load  = 1'b1;
                                byte_next = STAR_BYTE;
                            end
                            default:
                            begin
                                out_load = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        // ignored byte, or printable with the line full
                        out_load = 1'b0;
                    end
                end
            end
            ST_DUMP:
            begin
                // ram data holds while the output is stalled
                if (can_load)
                begin
                    out_load  = 1'b1;
                    kind_next = KIND_CHAR;
                    byte_next = ram_rd_data;
                    len_next  = n_reg;
                    last_next = (idx_inc == n_reg);
                    if (idx_inc == n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next    = idx_inc;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'(idx_inc);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            skip_reg       <= 1'b0;
            idx_reg        <= '0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
            echo_mode_reg  <= ECHO_MODE_RST;
            max_length_reg <= MAX_LENGTH_RST;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            skip_reg  <= skip_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ECHO_MODE)
                begin
                    echo_mode_reg <= cfg_data[1:0];
                end
                else if (cfg_index == CFG_MAX_LENGTH)
                begin
                    max_length_reg <= cfg_data;
                end
            end
        end
    end

    // output payload, no reset
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            len_reg  <= len_next;
            last_reg <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign out_byte    = byte_reg;
    assign line_length = len_reg;
    assign last        = last_reg;

`ifndef SYNTH
    // readout position always inside the line
    a_idx_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (idx_reg < n_reg))
        else $error("readout index past line length");

    // only line characters can be non-final beats
    a_nonlast_is_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (kind == KIND_CHAR))
        else $error("non-final beat that is not a line character");

    // count never exceeds what the buffer can keep
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CFG_DATA_W'(count_reg) <= KEEP_MAX_V)
        else $error("character count beyond buffer limit");

    // a readout that ends leaves a final line character in the output register
    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DUMP) && (state_next == ST_IDLE)) |=>
            (out_valid && last && (kind == KIND_CHAR)))
        else $error("readout ended without a final character beat");
`endif

endmodule
